[rtl/rors_pkg.sv]
package rors_pkg;

    localparam int VALUE_W = 32;
    localparam int RND_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int REQ_W   = 2;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 3;
    localparam int STEP_W  = 4;

    localparam logic [REQ_W-1:0] REQ_SET     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LIVE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;

    localparam logic [CFG_W-1:0] CFG_SOURCE_MODE = 3'd0;
    localparam logic [CFG_W-1:0] CFG_RANGED      = 3'd1;
    localparam logic [CFG_W-1:0] CFG_RANGE_LOW   = 3'd2;
    localparam logic [CFG_W-1:0] CFG_RANGE_HIGH  = 3'd3;
    localparam logic [CFG_W-1:0] CFG_HOLD        = 3'd4;

    typedef enum logic [STEP_W-1:0] {
        ST_IDLE      = 4'd0,
        ST_DISP      = 4'd1,
        ST_MODE_LIVE = 4'd2,
        ST_MODE_RPT  = 4'd3,
        ST_BAG_INIT  = 4'd4,
        ST_BAG_CNT   = 4'd5,
        ST_BAG_LEFT  = 4'd6,
        ST_BAG_RANK  = 4'd7,
        ST_BAG_SCAN  = 4'd8,
        ST_BAG_MARK  = 4'd9,
        ST_LIVE      = 4'd10,
        ST_RPT_SPAN  = 4'd11,
        ST_RPT_MUL   = 4'd12,
        ST_RPT_SUM   = 4'd13,
        ST_OUT       = 4'd15
    } t_step;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_BAG_INIT,
        OP_COUNT,
        OP_LEFT,
        OP_RANK,
        OP_SCAN,
        OP_MARK,
        OP_LIVE,
        OP_SPAN,
        OP_MUL,
        OP_RSUM,
        OP_OUTPUT
    } t_op;

    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NOT_GET,
        JC_HELD,
        JC_MODE_LIVE,
        JC_MODE_RPT,
        JC_CNT_MORE,
        JC_NOT_FOUND,
        JC_OUT_BUSY
    } t_jc;

    typedef struct packed {
        t_op   op;
        t_jc   jc;
        t_step target;
    } t_ctrl;

    // control store, fall-through goes to the next step (out wraps to idle)
    function automatic t_ctrl f_ucode(input t_step step);
        t_ctrl w;
        w = '{op: OP_NONE, jc: JC_ALWAYS, target: ST_IDLE};
        unique case (step)
            ST_IDLE:      w = '{op: OP_ACCEPT,   jc: JC_NOT_GET,   target: ST_IDLE};
            ST_DISP:      w = '{op: OP_NONE,     jc: JC_HELD,      target: ST_OUT};
            ST_MODE_LIVE: w = '{op: OP_NONE,     jc: JC_MODE_LIVE, target: ST_LIVE};
            ST_MODE_RPT:  w = '{op: OP_NONE,     jc: JC_MODE_RPT,  target: ST_RPT_SPAN};
            ST_BAG_INIT:  w = '{op: OP_BAG_INIT, jc: JC_NEVER,     target: ST_IDLE};
            ST_BAG_CNT:   w = '{op: OP_COUNT,    jc: JC_CNT_MORE,  target: ST_BAG_CNT};
            ST_BAG_LEFT:  w = '{op: OP_LEFT,     jc: JC_NEVER,     target: ST_IDLE};
            ST_BAG_RANK:  w = '{op: OP_RANK,     jc: JC_NEVER,     target: ST_IDLE};
            ST_BAG_SCAN:  w = '{op: OP_SCAN,     jc: JC_NOT_FOUND, target: ST_BAG_SCAN};
            ST_BAG_MARK:  w = '{op: OP_MARK,     jc: JC_ALWAYS,    target: ST_OUT};
            ST_LIVE:      w = '{op: OP_LIVE,     jc: JC_ALWAYS,    target: ST_OUT};
            ST_RPT_SPAN:  w = '{op: OP_SPAN,     jc: JC_NEVER,     target: ST_IDLE};
            ST_RPT_MUL:   w = '{op: OP_MUL,      jc: JC_NEVER,     target: ST_IDLE};
            ST_RPT_SUM:   w = '{op: OP_RSUM,     jc: JC_ALWAYS,    target: ST_OUT};
            ST_OUT:       w = '{op: OP_OUTPUT,   jc: JC_OUT_BUSY,  target: ST_OUT};
            default:      w = '{op: OP_NONE,     jc: JC_ALWAYS,    target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/ranged_or_random_value_source.sv]
// channel   direction  handshake                    payload
// request   in         i_in_valid / o_in_stall      i_req_type, i_new_value, i_random_bits
// result    out        o_out_valid / i_out_stall    o_value_out
// config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// set, restart and unused requests are handled in the idle step; a get runs through the
// microcode steps of its mode and goes straight to output when held; in no-repeat mode
// the two scans of the played bitmap read one bit per cycle.
// synchronous active-low reset clears config, live value, last result, hold and bitmap.
// a result waiting on i_out_stall holds the sequencer in its output step; a new
// request is taken as soon as the sequencer is back in idle.
module ranged_or_random_value_source #(
    parameter int POOL_SIZE = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rors_pkg::CFG_W-1:0]          i_cfg_index,
    input  logic [rors_pkg::VALUE_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rors_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [rors_pkg::VALUE_W-1:0] i_new_value,
    input  logic [rors_pkg::RND_W-1:0]          i_random_bits,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rors_pkg::VALUE_W-1:0] o_value_out
);

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam int RP_W  = rors_pkg::RND_W + CNT_W;

    // config registers
    logic [rors_pkg::MODE_W-1:0]          r_source_mode;
    logic                                 r_ranged;
    logic signed [rors_pkg::VALUE_W-1:0]  r_range_low;
    logic signed [rors_pkg::VALUE_W-1:0]  r_range_high;
    logic                                 r_hold_after;

    // sequencer
    rors_pkg::t_step r_step;
    rors_pkg::t_step n_step;
    rors_pkg::t_ctrl w_ctrl;
    logic            w_cond;

    // datapath
    logic signed [rors_pkg::VALUE_W-1:0] r_live;
    logic signed [rors_pkg::VALUE_W-1:0] r_last;
    logic                                r_hold;
    logic [POOL_SIZE-1:0]                r_map;
    logic [rors_pkg::RND_W-1:0]          r_rnd;
    logic [IDX_W-1:0]                    r_idx;
    logic [IDX_W-1:0]                    r_chosen;
    logic [CNT_W-1:0]                    r_count;
    logic [CNT_W-1:0]                    r_played;
    logic [CNT_W-1:0]                    r_left;
    logic [CNT_W-1:0]                    r_rank;
    logic signed [15:0]                  r_lo_int;
    logic signed [33:0]                  r_span;
    logic signed [49:0]                  r_prod;
    logic                                r_out_valid;
    logic signed [rors_pkg::VALUE_W-1:0] r_value;

    logic                                w_in_xfer;
    logic                                w_bit;
    logic                                w_found;
    logic [CNT_W-1:0]                    w_idx_inc;
    logic [16:0]                         w_diff;
    logic [CNT_W-1:0]                    w_count;
    logic [CNT_W-1:0]                    w_left;
    logic [RP_W-1:0]                     w_rank_prod;
    logic [16:0]                         w_bsum;
    logic [rors_pkg::VALUE_W-1:0]        w_bag_value;
    logic [rors_pkg::VALUE_W-1:0]        w_live_value;
    logic signed [50:0]                  w_mul;
    logic [49:0]                         w_adj;
    logic [33:0]                         w_quo;
    logic [34:0]                         w_rsum;
    logic [rors_pkg::VALUE_W-1:0]        w_rpt_value;

    assign o_in_stall  = (r_step != rors_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value_out = r_value;
    assign w_in_xfer   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_mode <= '0;
            r_ranged      <= 1'b0;
            r_range_low   <= '0;
            r_range_high  <= '0;
            r_hold_after  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rors_pkg::CFG_SOURCE_MODE: r_source_mode <= i_cfg_data[rors_pkg::MODE_W-1:0];
                rors_pkg::CFG_RANGED:      r_ranged      <= i_cfg_data[0];
                rors_pkg::CFG_RANGE_LOW:   r_range_low   <= i_cfg_data;
                rors_pkg::CFG_RANGE_HIGH:  r_range_high  <= i_cfg_data;
                rors_pkg::CFG_HOLD:        r_hold_after  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rors_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_ctrl = rors_pkg::f_ucode(r_step);
        unique case (w_ctrl.jc)
            rors_pkg::JC_NEVER:     w_cond = 1'b0;
            rors_pkg::JC_ALWAYS:    w_cond = 1'b1;
            rors_pkg::JC_NOT_GET:   w_cond = !(w_in_xfer && (i_req_type == rors_pkg::REQ_GET));
            rors_pkg::JC_HELD:      w_cond = r_hold_after && r_hold;
            rors_pkg::JC_MODE_LIVE: w_cond = (r_source_mode == rors_pkg::MODE_LIVE);
            rors_pkg::JC_MODE_RPT:  w_cond = (r_source_mode == rors_pkg::MODE_REPEAT);
            rors_pkg::JC_CNT_MORE:  w_cond = (w_idx_inc < r_count);
            rors_pkg::JC_NOT_FOUND: w_cond = !w_found;
            rors_pkg::JC_OUT_BUSY:  w_cond = r_out_valid && i_out_stall;
            default:                w_cond = 1'b1;
        endcase
        if (w_cond) begin
            n_step = w_ctrl.target;
        end else begin
            n_step = rors_pkg::t_step'(r_step + rors_pkg::STEP_W'(1));
        end
    end

    // bag helpers
    assign w_bit     = r_map[r_idx];
    assign w_found   = !w_bit && (r_rank == '0);
    assign w_idx_inc = CNT_W'(r_idx) + CNT_W'(1);
    assign w_diff    = {r_range_high[31], r_range_high[31:16]}
                     - {r_range_low[31], r_range_low[31:16]};
    assign w_left    = r_count - r_played;
    assign w_rank_prod = RP_W'(r_rnd) * RP_W'(r_left);
    assign w_bsum    = {r_lo_int[15], r_lo_int} + 17'(r_chosen);
    assign w_bag_value = (w_bsum[16] != w_bsum[15]) ? 32'h7FFF_FFFF
                                                    : {w_bsum[15:0], 16'h0000};

    always_comb begin
        if (w_diff[16]) begin
            w_count = CNT_W'(1);
        end else if (w_diff >= 17'(POOL_SIZE)) begin
            w_count = CNT_W'(POOL_SIZE);
        end else begin
            w_count = CNT_W'(w_diff) + CNT_W'(1);
        end
    end

    // live clamp
    always_comb begin
        w_live_value = r_live;
        if (r_ranged && (r_range_low < r_range_high)) begin
            if (r_live > r_range_low) begin
                w_live_value = (r_live < r_range_high) ? r_live : r_range_high;
            end else begin
                w_live_value = r_range_low;
            end
        end
    end

    // random with repetition
    assign w_mul  = $signed({1'b0, r_rnd}) * r_span;
    assign w_adj  = r_prod + {34'd0, {rors_pkg::FRAC_W{r_prod[49]}}};
    assign w_quo  = w_adj[49:16];
    assign w_rsum = {{3{r_range_low[31]}}, r_range_low} + {w_quo[33], w_quo};

    always_comb begin
        if ((w_rsum[34:31] == 4'b0000) || (w_rsum[34:31] == 4'b1111)) begin
            w_rpt_value = w_rsum[31:0];
        end else if (w_rsum[34]) begin
            w_rpt_value = 32'h8000_0000;
        end else begin
            w_rpt_value = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_last      <= '0;
            r_hold      <= 1'b0;
            r_map       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (w_ctrl.op != rors_pkg::OP_OUTPUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (w_ctrl.op)
                rors_pkg::OP_NONE: ;
                rors_pkg::OP_ACCEPT: begin
                    if (w_in_xfer) begin
                        unique case (i_req_type)
                            rors_pkg::REQ_SET:     r_live <= i_new_value;
                            rors_pkg::REQ_RESTART: r_hold <= 1'b0;
                            rors_pkg::REQ_GET:     r_rnd  <= i_random_bits;
                            default: ;
                        endcase
                    end
                end
                rors_pkg::OP_BAG_INIT: begin
                    r_lo_int <= r_range_low[31:16];
                    r_count  <= w_count;
                    r_idx    <= '0;
                    r_played <= '0;
                end
                rors_pkg::OP_COUNT: begin
                    if (w_bit) begin
                        r_played <= r_played + CNT_W'(1);
                    end
                    r_idx <= r_idx + IDX_W'(1);
                end
                rors_pkg::OP_LEFT: begin
                    if (w_left == '0) begin
                        r_map  <= '0;
                        r_left <= r_count;
                    end else begin
                        r_left <= w_left;
                    end
                end
                rors_pkg::OP_RANK: begin
                    r_rank <= w_rank_prod[rors_pkg::RND_W +: CNT_W];
                    r_idx  <= '0;
                end
                rors_pkg::OP_SCAN: begin
                    if (!w_bit) begin
                        if (r_rank == '0) begin
                            r_chosen <= r_idx;
                        end else begin
                            r_rank <= r_rank - CNT_W'(1);
                        end
                    end
                    r_idx <= r_idx + IDX_W'(1);
                end
                rors_pkg::OP_MARK: begin
                    // last unplayed entry taken: start a fresh bag
                    if (r_left <= CNT_W'(1)) begin
                        r_map <= '0;
                    end else begin
                        r_map[r_chosen] <= 1'b1;
                    end
                    r_last <= w_bag_value;
                end
                rors_pkg::OP_LIVE: r_last <= w_live_value;
                rors_pkg::OP_SPAN: begin
                    r_span <= {{2{r_range_high[31]}}, r_range_high}
                            - {{2{r_range_low[31]}}, r_range_low} + 34'sd65536;
                end
                rors_pkg::OP_MUL:  r_prod <= w_mul[49:0];
                rors_pkg::OP_RSUM: r_last <= w_rpt_value;
                rors_pkg::OP_OUTPUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_value     <= r_last;
                        r_hold      <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    a_scan_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == rors_pkg::ST_BAG_SCAN) |-> (CNT_W'(r_idx) < r_count))
        else $error("bag scan ran past pool");

    a_rank_below_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == rors_pkg::ST_BAG_RANK) |=> (r_rank < r_left))
        else $error("rank not below unplayed count");

    a_played_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == rors_pkg::ST_BAG_CNT) |-> (r_played < r_count))
        else $error("played count reached pool size");

    a_held_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == rors_pkg::ST_DISP) && r_hold_after && r_hold)
        |=> ((r_step == rors_pkg::ST_OUT) && $stable(r_last)))
        else $error("held get did not repeat last result");

endmodule

[tb/ranged_or_random_value_source_test.sv]
module ranged_or_random_value_source_test;

    localparam int     POOL       = 64;
    localparam longint ONE        = 64'sd65536;
    localparam longint MAX32      = 64'sd2147483647;
    localparam longint MIN32      = -64'sd2147483648;
    localparam int     SETTLE     = 8;
    localparam int     HANG_LIMIT = 4000;
    localparam int     RANDOM_ITEMS = 1720;

    localparam logic [rors_pkg::MODE_W-1:0] MODE_BAG     = 2'd2;
    localparam logic [rors_pkg::MODE_W-1:0] MODE_BAG_ALT = 2'd3;
    localparam logic [rors_pkg::REQ_W-1:0]  REQ_UNUSED   = 2'd3;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [rors_pkg::CFG_W-1:0]          i_cfg_index = '0;
    logic [rors_pkg::VALUE_W-1:0]        i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [rors_pkg::REQ_W-1:0]          i_req_type = rors_pkg::REQ_SET;
    logic signed [rors_pkg::VALUE_W-1:0] i_new_value = '0;
    logic [rors_pkg::RND_W-1:0]          i_random_bits = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic signed [rors_pkg::VALUE_W-1:0] o_value_out;

    ranged_or_random_value_source #(.POOL_SIZE(POOL)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_new_value   (i_new_value),
        .i_random_bits (i_random_bits),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value_out   (o_value_out)
    );

    always #4 i_clk = ~i_clk;

    // predicted block state
    logic [rors_pkg::MODE_W-1:0]         cfg_mode = rors_pkg::MODE_LIVE;
    logic                                cfg_ranged = 1'b0;
    logic signed [rors_pkg::VALUE_W-1:0] cfg_low = '0;
    logic signed [rors_pkg::VALUE_W-1:0] cfg_high = '0;
    logic                                cfg_hold = 1'b0;
    logic signed [rors_pkg::VALUE_W-1:0] live_q = '0;
    logic signed [rors_pkg::VALUE_W-1:0] last_q = '0;
    logic                                held = 1'b0;
    logic [POOL-1:0]                     played = '0;

    logic signed [rors_pkg::VALUE_W-1:0] expected_values[$];
    logic signed [rors_pkg::VALUE_W-1:0] want;

    bit quiet = 1'b0;
    int fail_count = 0;
    int values_checked = 0;
    int requests_sent = 0;
    int random_items = 0;
    int settings_used = 0;
    int idle_run = 0;

    function automatic logic signed [rors_pkg::VALUE_W-1:0] clip32(input longint v);
        if (v > MAX32) return MAX32[rors_pkg::VALUE_W-1:0];
        if (v < MIN32) return MIN32[rors_pkg::VALUE_W-1:0];
        return v[rors_pkg::VALUE_W-1:0];
    endfunction

    function automatic logic signed [rors_pkg::VALUE_W-1:0] live_pick();
        if (cfg_ranged && cfg_low < cfg_high) begin
            if (live_q > cfg_low) return (live_q < cfg_high) ? live_q : cfg_high;
            return cfg_low;
        end
        return live_q;
    endfunction

    function automatic logic signed [rors_pkg::VALUE_W-1:0] repeat_pick(
        input logic [rors_pkg::RND_W-1:0] rnd);
        longint span;
        longint prod;
        span = longint'(cfg_high) - longint'(cfg_low) + ONE;
        prod = longint'(rnd) * span;
        return clip32(longint'(cfg_low) + prod / ONE);
    endfunction

    function automatic logic signed [rors_pkg::VALUE_W-1:0] bag_pick(
        input logic [rors_pkg::RND_W-1:0] rnd);
        longint base;
        longint top;
        longint span;
        int     count;
        int     taken;
        int     left;
        int     rank;
        int     chosen;
        bit     found;
        base = longint'(cfg_low) >>> rors_pkg::FRAC_W;
        top  = longint'(cfg_high) >>> rors_pkg::FRAC_W;
        span = (top >= base) ? top - base + 1 : 1;
        count = (span > POOL) ? POOL : int'(span);
        taken = 0;
        for (int i = 0; i < count; i++) taken += played[i];
        left = count - taken;
        // nothing unplayed in the pool, start a fresh bag
        if (left == 0) begin
            played = '0;
            left = count;
        end
        rank = int'((longint'(rnd) * left) >>> rors_pkg::FRAC_W);
        chosen = 0;
        found = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (!found && !played[i]) begin
                if (rank == 0) begin
                    chosen = i;
                    found = 1'b1;
                end else begin
                    rank--;
                end
            end
        end
        played[chosen] = 1'b1;
        if (left <= 1) played = '0;
        return clip32((base + chosen) * ONE);
    endfunction

    task automatic track_request(input logic [rors_pkg::REQ_W-1:0] req,
                                 input logic [rors_pkg::VALUE_W-1:0] nv,
                                 input logic [rors_pkg::RND_W-1:0] rnd);
        case (req)
            rors_pkg::REQ_SET: begin
                live_q = nv;
            end
            rors_pkg::REQ_RESTART: begin
                held = 1'b0;
            end
            rors_pkg::REQ_GET: begin
                if (!(cfg_hold && held)) begin
                    if (cfg_mode == rors_pkg::MODE_LIVE) last_q = live_pick();
                    else if (cfg_mode == rors_pkg::MODE_REPEAT) last_q = repeat_pick(rnd);
                    else last_q = bag_pick(rnd);
                end
                held = 1'b1;
                expected_values = {expected_values, last_q};
            end
            default: begin
            end
        endcase
    endtask

    task automatic apply_reg(input logic [rors_pkg::CFG_W-1:0] idx,
                             input logic [rors_pkg::VALUE_W-1:0] data);
        case (idx)
            rors_pkg::CFG_SOURCE_MODE: cfg_mode = data[rors_pkg::MODE_W-1:0];
            rors_pkg::CFG_RANGED:      cfg_ranged = data[0];
            rors_pkg::CFG_RANGE_LOW:   cfg_low = data;
            rors_pkg::CFG_RANGE_HIGH:  cfg_high = data;
            rors_pkg::CFG_HOLD:        cfg_hold = data[0];
            default: begin
            end
        endcase
    endtask

    task automatic write_one(input logic [rors_pkg::CFG_W-1:0] idx,
                             input logic [rors_pkg::VALUE_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    // only called with the block idle
    task automatic write_regs(input logic [rors_pkg::MODE_W-1:0] mode, input logic ranged,
                              input logic [rors_pkg::VALUE_W-1:0] lo,
                              input logic [rors_pkg::VALUE_W-1:0] hi,
                              input logic hold);
        logic [rors_pkg::VALUE_W-1:0] junk;
        junk = $urandom;
        write_one(rors_pkg::CFG_SOURCE_MODE,
                  {junk[rors_pkg::VALUE_W-1:rors_pkg::MODE_W], mode});
        write_one(rors_pkg::CFG_RANGED, {junk[rors_pkg::VALUE_W-2:0], ranged});
        write_one(rors_pkg::CFG_RANGE_LOW, lo);
        write_one(rors_pkg::CFG_RANGE_HIGH, hi);
        write_one(rors_pkg::CFG_HOLD, {junk[rors_pkg::VALUE_W-1:1], hold});
        if ($urandom_range(99) < 20)
            write_one(rors_pkg::CFG_W'($urandom_range(5, 7)), $urandom);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_req(input logic [rors_pkg::REQ_W-1:0] req,
                            input logic [rors_pkg::VALUE_W-1:0] nv,
                            input logic [rors_pkg::RND_W-1:0] rnd);
        if (!quiet && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_new_value <= nv;
        i_random_bits <= rnd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_request(req, nv, rnd);
        requests_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_live_value();
        send_req(rors_pkg::REQ_GET, $urandom, rors_pkg::RND_W'($urandom));
        send_req(REQ_UNUSED, $urandom, rors_pkg::RND_W'($urandom));
        send_req(rors_pkg::REQ_SET, 32'h8000_0000, 16'h0000);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'hFFFF);
        send_req(rors_pkg::REQ_SET, 32'h7FFF_FFFF, 16'h0000);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h0000);
        drain();
        // clamp between -2.0 and 3.5
        write_regs(rors_pkg::MODE_LIVE, 1'b1, -32'sd131072, 32'sd229376, 1'b0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h0);
        send_req(rors_pkg::REQ_SET, -32'sd131072, 16'h0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h0);
        drain();
        // equal bounds leave the live value raw
        write_regs(rors_pkg::MODE_LIVE, 1'b1, 32'sd65536, 32'sd65536, 1'b0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h0);
    endtask

    task automatic test_hold();
        drain();
        write_regs(rors_pkg::MODE_REPEAT, 1'b0, 32'sd0, 32'sd655360, 1'b1);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h1234);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'hFFFF);
        send_req(rors_pkg::REQ_SET, 32'h1234_5678, 16'h0);
        send_req(rors_pkg::REQ_RESTART, 32'h0, 16'h0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'hFFFF);
    endtask

    task automatic test_repeat_range();
        drain();
        write_regs(rors_pkg::MODE_REPEAT, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h0000);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'hFFFF);
        drain();
        // sum runs past the top of the range
        write_regs(rors_pkg::MODE_REPEAT, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'hFFFF);
        drain();
        // reversed range, negative span
        write_regs(rors_pkg::MODE_REPEAT, 1'b0, 32'sd327680, -32'sd196608, 1'b0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h8000);
    endtask

    task automatic test_bag();
        drain();
        // -1.5 .. 1.25 gives a pool of four integers, five picks wrap the bag
        write_regs(MODE_BAG, 1'b0, -32'sd98304, 32'sd81920, 1'b0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'hFFFF);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h0000);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h8000);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'hFFFF);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'h4000);
        drain();
        // full range, pool capped, stale bit from the last bag
        write_regs(MODE_BAG_ALT, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'hFFFF);
        drain();
        write_regs(MODE_BAG, 1'b0, 32'sd655360, -32'sd655360, 1'b0);
        send_req(rors_pkg::REQ_GET, 32'h0, 16'hFFFF);
    endtask

    task automatic random_config();
        logic [rors_pkg::VALUE_W-1:0] lo;
        logic [rors_pkg::VALUE_W-1:0] hi;
        logic [rors_pkg::VALUE_W-1:0] edges[5];
        int pick;
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
        pick = $urandom_range(99);
        if (pick < 40) begin
            lo = (($urandom_range(80) - 40) << rors_pkg::FRAC_W) | $urandom_range(65535);
            hi = lo + ($urandom_range(70) << rors_pkg::FRAC_W) + $urandom_range(65535);
        end else if (pick < 60) begin
            lo = $urandom;
            hi = $urandom;
        end else if (pick < 75) begin
            lo = edges[$urandom_range(4)];
            hi = edges[$urandom_range(4)];
        end else if (pick < 90) begin
            hi = (($urandom_range(80) - 40) << rors_pkg::FRAC_W) | $urandom_range(65535);
            lo = hi + ($urandom_range(1, 20) << rors_pkg::FRAC_W);
        end else begin
            lo = $urandom;
            hi = lo;
        end
        write_regs(rors_pkg::MODE_W'($urandom_range(3)), 1'($urandom_range(1)), lo, hi,
                   $urandom_range(99) < 25);
    endtask

    task automatic test_random_phases();
        int phase;
        int phase_items;
        int pick;
        logic [rors_pkg::REQ_W-1:0]   req;
        logic [rors_pkg::VALUE_W-1:0] nv;
        logic [rors_pkg::RND_W-1:0]   rnd;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain();
            quiet = (phase >= 10 && phase < 14);
            random_config();
            phase_items = $urandom_range(40, 80);
            for (int k = 0; k < phase_items; k++) begin
                pick = $urandom_range(99);
                if (pick < 60) req = rors_pkg::REQ_GET;
                else if (pick < 82) req = rors_pkg::REQ_SET;
                else if (pick < 95) req = rors_pkg::REQ_RESTART;
                else req = REQ_UNUSED;
                if ($urandom_range(1)) nv = $urandom;
                else nv = cfg_low + $urandom_range(32'h60000) - 32'h20000;
                pick = $urandom_range(19);
                if (pick == 0) rnd = '0;
                else if (pick == 1) rnd = '1;
                else rnd = rors_pkg::RND_W'($urandom_range(65535));
                send_req(req, nv, rnd);
                if (req != REQ_UNUSED) random_items++;
                // sender waits for every outstanding value mid phase
                if (k == phase_items / 2) drain();
            end
            phase++;
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_values.size() == 0) begin
                if (fail_count < 10) $display("unexpected value_out %h", o_value_out);
                fail_count++;
            end else begin
                want = expected_values.pop_front();
                if (o_value_out !== want) begin
                    if (fail_count < 10)
                        $display("value_out mismatch: expected %h, got %h", want, o_value_out);
                    fail_count++;
                end
                values_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_run <= 0;
        else idle_run <= idle_run + 1;
    end

    initial begin
        while (idle_run < HANG_LIMIT) @(posedge i_clk);
        $display("no transfer for %0d cycles", HANG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_live_value();
        test_hold();
        test_repeat_range();
        test_bag();
        test_random_phases();
        drain();
        $display("sent %0d requests (%0d random) across %0d register settings",
                 requests_sent, random_items, settings_used);
        $display("checked %0d values from live, repeat and no-repeat sources", values_checked);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
